// ----- rtl/core/fbba_pkg.sv -----
`timescale 1ns / 1ps

package fbba_pkg;

    localparam int unsigned MAP_BYTES_DEF = 512;
    localparam int unsigned BYTE_W        = 8;
    localparam int unsigned BIT_W         = 3;
    localparam int unsigned CMD_W         = 2;
    localparam int unsigned BLOCK_W       = 12;
    localparam int unsigned IDX_W         = BLOCK_W - BIT_W;

    typedef enum logic [CMD_W-1:0] {
        CMD_ALLOC   = 2'd0,
        CMD_BUSY    = 2'd1,
        CMD_RELEASE = 2'd2
    } t_cmd;

    // Position of the lowest set bit; only meaningful for a non-zero byte.
    function automatic logic [BIT_W-1:0] lowest_set(input logic [BYTE_W-1:0] v);
        logic [BIT_W-1:0] pos;
        pos = '0;
        for (int i = BYTE_W - 1; i >= 0; i--) begin
            if (v[i]) begin
                pos = BIT_W'(i);
            end
        end
        return pos;
    endfunction

endpackage

// ----- rtl/core/fbba_if.sv -----
`timescale 1ns / 1ps

interface fbba_req_if import fbba_pkg::*;;
    logic               valid;
    logic               ready;
    logic [CMD_W-1:0]   cmd;
    logic [BLOCK_W-1:0] block;

    modport source (output valid, cmd, block, input ready);
    modport sink   (input valid, cmd, block, output ready);
endinterface

interface fbba_rsp_if import fbba_pkg::*;;
    logic               valid;
    logic               ready;
    logic [BLOCK_W-1:0] given_block;
    logic               no_free;

    modport source (output valid, given_block, no_free, input ready);
    modport sink   (input valid, given_block, no_free, output ready);
endinterface

// ----- rtl/core/free_block_bitmap_allocator_core.sv -----
`timescale 1ns / 1ps

// Free-block bitmap allocator. One bit per storage block is kept in a single-port-style
// byte memory (set bit = free). A request transaction carries allocate, mark busy or
// release; each produces exactly one response transaction. After reset a clearing pass
// writes every byte to all ones, during which no request is accepted. Mark busy and
// release of a block inside the map pass through a memory read, a write back, and the
// response register before their response is presented. Allocate reads the bitmap one
// byte per cycle starting at a pointer below which every byte is known to be fully busy,
// and stops at the first byte with a free bit or at the last byte of the map. Once the
// map is known to be full, allocate skips the scan and goes straight to the response
// register. The next request can be accepted in the cycle the response is presented.
// Only one request is in progress at a time, but a new request is accepted while the
// previous response still waits to be taken.
module free_block_bitmap_allocator_core import fbba_pkg::*; #(
    parameter int unsigned MAP_BYTES = MAP_BYTES_DEF
) (
    input  logic        i_clk,
    input  logic        i_rst_n,
    fbba_req_if.sink    i_req,
    fbba_rsp_if.source  o_rsp
);

    localparam int unsigned AW = (MAP_BYTES > 1) ? $clog2(MAP_BYTES) : 1;
    localparam int unsigned HW = $clog2(MAP_BYTES + 1);
    localparam logic [HW-1:0] HINT_END  = HW'(MAP_BYTES);
    localparam logic [AW-1:0] ADDR_LAST = AW'(MAP_BYTES - 1);

    typedef enum logic [2:0] {
        ST_CLEAR,
        ST_IDLE,
        ST_MOD,
        ST_SCAN,
        ST_DONE
    } t_state;

    t_state             r_state;
    logic [AW-1:0]      r_addr;
    logic [HW-1:0]      r_hint;
    t_cmd               r_cmd;
    logic [BIT_W-1:0]   r_bit;
    logic [BLOCK_W-1:0] r_res_block;
    logic               r_res_nf;
    logic               r_out_valid;
    logic [BLOCK_W-1:0] r_out_block;
    logic               r_out_nf;

    logic [BYTE_W-1:0]  mem [MAP_BYTES];
    logic [BYTE_W-1:0]  r_rdata;

    logic               accept;
    logic [IDX_W-1:0]   req_idx;
    logic               req_in_range;
    logic [AW-1:0]      req_addr;
    logic [AW-1:0]      hint_addr;
    logic [BIT_W-1:0]   hit_bit;
    logic [BYTE_W-1:0]  hit_byte;
    logic               rd_en;
    logic [AW-1:0]      rd_addr;
    logic               wr_en;
    logic [BYTE_W-1:0]  wr_data;
    logic               out_free;

    assign accept       = i_req.valid && (r_state == ST_IDLE);
    assign req_idx      = i_req.block[BLOCK_W-1:BIT_W];
    assign req_in_range = 32'(req_idx) < MAP_BYTES;
    assign req_addr     = AW'(32'(req_idx));
    assign hint_addr    = AW'(r_hint);
    assign hit_bit      = lowest_set(r_rdata);
    assign hit_byte     = r_rdata & ~(BYTE_W'(1) << hit_bit);
    assign out_free     = !r_out_valid || o_rsp.ready;

    always_comb begin
        rd_en   = 1'b0;
        rd_addr = r_addr + AW'(1);
        if (accept) begin
            rd_addr = (t_cmd'(i_req.cmd) == CMD_ALLOC) ? hint_addr : req_addr;
            unique case (i_req.cmd)
                CMD_ALLOC:             rd_en = (r_hint != HINT_END);
                CMD_BUSY, CMD_RELEASE: rd_en = req_in_range;
                default:               rd_en = 1'b0;
            endcase
        end else if (r_state == ST_SCAN) begin
            rd_en = (r_rdata == '0) && (r_addr != ADDR_LAST);
        end
    end

    always_comb begin
        wr_en   = 1'b0;
        wr_data = '1;
        unique case (r_state)
            ST_CLEAR: wr_en = 1'b1;
            ST_MOD: begin
                wr_en   = 1'b1;
                wr_data = (r_cmd == CMD_RELEASE) ? (r_rdata | (BYTE_W'(1) << r_bit))
                                                 : (r_rdata & ~(BYTE_W'(1) << r_bit));
            end
            ST_SCAN: begin
                wr_en   = (r_rdata != '0);
                wr_data = hit_byte;
            end
            default: wr_en = 1'b0;
        endcase
    end

    // Accesses never overlap on one entry: a write from ST_MOD or ST_SCAN is followed by
    // ST_DONE before the next request can issue a read, and none is read while clearing.
    always_ff @(posedge i_clk) begin
        if (wr_en) begin
            mem[r_addr] <= wr_data;
        end
        if (rd_en) begin
            r_rdata <= mem[rd_addr];
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= ST_CLEAR;
            r_addr      <= '0;
            r_hint      <= '0;
            r_out_valid <= 1'b0;
        end else begin
            if (r_out_valid && o_rsp.ready) begin
                r_out_valid <= 1'b0;
            end
            unique case (r_state)
                ST_CLEAR: begin
                    r_addr <= r_addr + AW'(1);
                    if (r_addr == ADDR_LAST) begin
                        r_addr  <= '0;
                        r_state <= ST_IDLE;
                    end
                end
                ST_IDLE: begin
                    if (accept) begin
                        r_cmd       <= t_cmd'(i_req.cmd);
                        r_bit       <= i_req.block[BIT_W-1:0];
                        r_res_block <= i_req.block;
                        r_res_nf    <= 1'b0;
                        r_addr      <= req_addr;
                        unique case (i_req.cmd)
                            CMD_ALLOC: begin
                                if (r_hint == HINT_END) begin
                                    r_res_block <= '0;
                                    r_res_nf    <= 1'b1;
                                    r_state     <= ST_DONE;
                                end else begin
                                    r_addr  <= hint_addr;
                                    r_state <= ST_SCAN;
                                end
                            end
                            CMD_BUSY, CMD_RELEASE: begin
                                r_state <= req_in_range ? ST_MOD : ST_DONE;
                            end
                            default: r_state <= ST_DONE;
                        endcase
                    end
                end
                ST_MOD: begin
                    // A released block below the pointer moves the pointer down.
                    if ((r_cmd == CMD_RELEASE) && (HW'(r_addr) < r_hint)) begin
                        r_hint <= HW'(r_addr);
                    end
                    r_state <= ST_DONE;
                end
                ST_SCAN: begin
                    if (r_rdata != '0) begin
                        r_res_block <= BLOCK_W'({r_addr, hit_bit});
                        r_hint      <= (hit_byte == '0) ? HW'(r_addr) + HW'(1) : HW'(r_addr);
                        r_state     <= ST_DONE;
                    end else if (r_addr == ADDR_LAST) begin
                        r_res_block <= '0;
                        r_res_nf    <= 1'b1;
                        r_hint      <= HINT_END;
                        r_state     <= ST_DONE;
                    end else begin
                        r_addr <= r_addr + AW'(1);
                    end
                end
                ST_DONE: begin
                    if (out_free) begin
                        r_out_valid <= 1'b1;
                        r_out_block <= r_res_block;
                        r_out_nf    <= r_res_nf;
                        r_state     <= ST_IDLE;
                    end
                end
                default: r_state <= ST_IDLE;
            endcase
        end
    end

    assign i_req.ready       = (r_state == ST_IDLE);
    assign o_rsp.valid       = r_out_valid;
    assign o_rsp.given_block = r_out_block;
    assign o_rsp.no_free     = r_out_nf;

`ifndef NO_ASSERTIONS
    a_no_accept_in_clear: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == ST_CLEAR) |-> !i_req.ready)
        else $error("request accepted during the clearing pass");

    a_one_in_flight: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_req.valid && i_req.ready) |=> !i_req.ready)
        else $error("second request accepted while one is in progress");

    a_hint_bound: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_hint <= HINT_END)
        else $error("free pointer beyond the map");

    a_no_free_zero: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_rsp.valid && o_rsp.no_free) |-> (o_rsp.given_block == '0))
        else $error("no_free response with a non-zero block number");

    a_no_rw_collide: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (wr_en && rd_en) |-> (rd_addr != r_addr))
        else $error("read and write of the same entry in one cycle");
`endif

endmodule

// ----- dv/tb_free_block_bitmap_allocator_core.sv -----
`timescale 1ns / 1ps

module tb_free_block_bitmap_allocator_core import fbba_pkg::*;;

    localparam int unsigned MAP_BYTES  = MAP_BYTES_DEF;
    localparam int unsigned QUIET_LIMIT = 4000;
    localparam int unsigned PHASE_ITEMS = 460;

    // The command encoding that the package leaves without a name.
    localparam logic [CMD_W-1:0] CMD_UNUSED = 2'd3;

    typedef struct packed {
        logic [BLOCK_W-1:0] given_block;
        logic               no_free;
    } t_alloc_result;

    class alloc_scoreboard;
        bit [BYTE_W-1:0] free_map [MAP_BYTES];
        t_alloc_result   expected_q [$];
        int unsigned     mismatches;

        function new();
            foreach (free_map[i]) begin
                free_map[i] = '1;
            end
            mismatches  = 0;
        endfunction

        // Update the bitmap for an accepted request and queue the response it must give.
        function void note_request(logic [CMD_W-1:0] cmd, logic [BLOCK_W-1:0] blk);
            t_alloc_result r;
            int unsigned   idx;
            int unsigned   pos;
            int unsigned   i;
            int unsigned   b;
            int unsigned   hit;
            bit            found;
            r.given_block = blk;
            r.no_free     = 1'b0;
            idx   = blk >> BIT_W;
            pos   = blk[BIT_W-1:0];
            found = 1'b0;
            hit   = 0;
            case (cmd)
                CMD_ALLOC: begin
                    for (i = 0; i < MAP_BYTES && !found; i++) begin
                        for (b = 0; b < BYTE_W && !found; b++) begin
                            if (free_map[i][b]) begin
                                found = 1'b1;
                                hit   = i * BYTE_W + b;
                            end
                        end
                    end
                    if (found) begin
                        free_map[hit / BYTE_W][hit % BYTE_W] = 1'b0;
                        r.given_block = BLOCK_W'(hit);
                    end else begin
                        r.given_block = '0;
                        r.no_free     = 1'b1;
                    end
                end
                CMD_BUSY: begin
                    if (idx < MAP_BYTES) begin
                        free_map[idx][pos] = 1'b0;
                    end
                end
                CMD_RELEASE: begin
                    if (idx < MAP_BYTES) begin
                        free_map[idx][pos] = 1'b1;
                    end
                end
                default: ;
            endcase
            expected_q.push_back(r);
        endfunction

        function void report(string what);
            mismatches++;
            if (mismatches <= 10) $display("%0t: %s", $realtime, what);
        endfunction

        function void check_result(logic [BLOCK_W-1:0] given, logic no_free);
            t_alloc_result exp_r;
            if (expected_q.size() == 0) begin
                report($sformatf("response with none expected: given_block %0d no_free %0d",
                                 given, no_free));
            end else begin
                exp_r = expected_q.pop_front();
                if (given !== exp_r.given_block || no_free !== exp_r.no_free) begin
                    report($sformatf({"mismatch: expected given_block %0d no_free %0d, ",
                                      "got given_block %0d no_free %0d"},
                                     exp_r.given_block, exp_r.no_free, given, no_free));
                end
            end
        endfunction

        function int unsigned pending();
            return expected_q.size();
        endfunction
    endclass

    logic i_clk;
    logic i_rst_n;

    fbba_req_if req_if ();
    fbba_rsp_if rsp_if ();

    free_block_bitmap_allocator_core #(
        .MAP_BYTES (MAP_BYTES)
    ) u_dut (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_req   (req_if),
        .o_rsp   (rsp_if)
    );

    alloc_scoreboard sb;
    int unsigned     idle_pct;
    int unsigned     stall_pct;
    int unsigned     quiet_cycles;

    initial begin
        i_clk = 1'b0;
    end

    always begin
        #2 i_clk = 1'b1;
        #2 i_clk = 1'b0;
    end

    // Response side: check every accepted transaction and stall at random.
    always @(posedge i_clk) begin
        if (rsp_if.valid && rsp_if.ready) begin
            sb.check_result(rsp_if.given_block, rsp_if.no_free);
        end
        rsp_if.ready <= ($urandom_range(99) >= stall_pct);
    end

    // Watchdog on cycles in which no transaction moves on either side.
    always @(posedge i_clk) begin
        if (!i_rst_n || (req_if.valid && req_if.ready) || (rsp_if.valid && rsp_if.ready)) begin
            quiet_cycles <= 0;
        end else if (quiet_cycles >= QUIET_LIMIT) begin
            $display("simulation failed");
            $finish;
        end else begin
            quiet_cycles <= quiet_cycles + 1;
        end
    end

    task automatic send_req(logic [CMD_W-1:0] cmd, logic [BLOCK_W-1:0] blk);
        while ($urandom_range(99) < idle_pct) begin
            req_if.valid <= 1'b0;
            @(posedge i_clk);
        end
        req_if.valid <= 1'b1;
        req_if.cmd   <= cmd;
        req_if.block <= blk;
        @(posedge i_clk);
        while (!req_if.ready) @(posedge i_clk);
        sb.note_request(cmd, blk);
    endtask

    // Lower valid and hold off until every queued response has been taken.
    task automatic drain();
        req_if.valid <= 1'b0;
        @(posedge i_clk);
        while (sb.pending() != 0) @(posedge i_clk);
    endtask

    function automatic logic [CMD_W-1:0] pick_cmd();
        int unsigned sel;
        sel = $urandom_range(99);
        if (sel < 40) return CMD_ALLOC;
        if (sel < 62) return CMD_BUSY;
        if (sel < 96) return CMD_RELEASE;
        return CMD_UNUSED;
    endfunction

    // Most block numbers fall where allocations land, so releases and mark busy
    // requests fragment the allocated region.
    function automatic logic [BLOCK_W-1:0] pick_block();
        int unsigned sel;
        sel = $urandom_range(99);
        if (sel < 55) return BLOCK_W'($urandom_range(1023));
        if (sel < 58) return '1;
        if (sel < 61) return '0;
        return BLOCK_W'($urandom);
    endfunction

    initial begin
        int unsigned idle_tbl [4];
        int unsigned stall_tbl [4];
        idle_tbl  = '{0, 75, 0, 31};
        stall_tbl = '{0, 0, 75, 31};
        sb        = new();
        idle_pct  = 0;
        stall_pct = 0;
        req_if.valid <= 1'b0;
        req_if.cmd   <= CMD_ALLOC;
        req_if.block <= '0;
        i_rst_n      <= 1'b0;
        repeat (10) @(posedge i_clk);
        i_rst_n <= 1'b1;

        // Directed: fresh allocations, both ends of the block range, unused command.
        send_req(CMD_ALLOC, '1);
        send_req(CMD_ALLOC, '0);
        send_req(CMD_ALLOC, 12'hAAA);
        send_req(CMD_BUSY, 12'd4095);
        send_req(CMD_RELEASE, 12'd4095);
        send_req(CMD_BUSY, 12'd0);
        send_req(CMD_RELEASE, 12'd1);
        send_req(CMD_ALLOC, 12'h555);
        send_req(CMD_BUSY, 12'd3);
        send_req(CMD_BUSY, 12'd8);
        send_req(CMD_ALLOC, 12'd0);
        send_req(CMD_ALLOC, 12'd0);
        send_req(CMD_UNUSED, 12'd4095);
        send_req(CMD_UNUSED, 12'd0);
        send_req(CMD_RELEASE, 12'd0);
        send_req(CMD_RELEASE, 12'd2);
        send_req(CMD_ALLOC, 12'd0);
        send_req(CMD_ALLOC, 12'd0);
        send_req(CMD_BUSY, 12'h7FF);
        send_req(CMD_RELEASE, 12'h800);
        send_req(CMD_RELEASE, 12'hAAA);
        send_req(CMD_BUSY, 12'h555);
        drain();

        for (int p = 0; p < 4; p++) begin
            idle_pct  = idle_tbl[p];
            stall_pct = stall_tbl[p];
            for (int n = 0; n < PHASE_ITEMS; n++) begin
                send_req(pick_cmd(), pick_block());
            end
            drain();
        end

        repeat (MAP_BYTES + 8) @(posedge i_clk);
        if (sb.mismatches == 0 && sb.pending() == 0) begin
            $display("simulation ok");
        end else begin
            $display("simulation failed");
        end
        $finish;
    end

endmodule
